// File: hw/rtl/rsi_pkg.sv
// ============================================================================
// rsi_pkg
// Shared constants, types and helpers for the ray/segment intersection unit.
// ============================================================================
package rsi_pkg;

    // Fixed-point format: signed Q(32-FRAC_BITS).FRAC_BITS
    localparam int FRAC_BITS = 16;
    // Width of the ray parameter t and the distance field
    localparam int T_W       = 31;
    // Low numerator bits shifted into the long division, one per step from the first
    localparam int DIVN      = T_W - FRAC_BITS;
    localparam logic [T_W-1:0] MAX_T = {T_W{1'b1}};

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_START_X   = 3'd0,
        CFG_START_Y   = 3'd1,
        CFG_SPAN_X    = 3'd2,
        CFG_SPAN_Y    = 3'd3,
        CFG_PAR_THR   = 3'd4,
        CFG_MIN_DIST  = 3'd5
    } t_cfg_idx;

    // Per-ray data that rides along the divider
    typedef struct packed {
        logic signed [31:0] ox;
        logic signed [31:0] oy;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic               pass;
        logic               sat;
    } t_side;

    // Saturate a wide signed value to signed 32 bits
    function automatic logic signed [31:0] sat_s32(input logic signed [64:0] v);
        logic signed [31:0] res;
        if (v > 65'sd2147483647) begin
            res = 32'sh7FFF_FFFF;
        end else if (v < -65'sd2147483648) begin
            res = 32'sh8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

endpackage

// File: hw/rtl/rsi_divider.sv
// ============================================================================
// rsi_divider
// Pipelined restoring divider: quotient = floor(num * 2^FRAC_BITS / den),
// one quotient bit per stage, T_W stages, with a stall-safe ready chain.
// ============================================================================
module rsi_divider (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [63:0]               i_num,
    input  logic [63:0]               i_den,
    input  rsi_pkg::t_side            i_side,
    output logic                      o_valid,
    input  logic                      i_ready,
    output logic [rsi_pkg::T_W-1:0]   o_quot,
    output rsi_pkg::t_side            o_side
);
    import rsi_pkg::*;

    localparam int NSTG = T_W;

    typedef struct packed {
        logic [63:0]     d;
        logic [63:0]     r;
        logic [T_W-1:0]  q;
        logic [DIVN-1:0] nl;
        t_side           side;
    } t_dstg;

    // One restoring step producing quotient bit bitpos
    function automatic t_dstg div_step(input t_dstg s, input int bitpos);
        t_dstg      o;
        logic [64:0] rs;
        logic       nb;
        o  = s;
        nb = 1'b0;
        if (bitpos >= FRAC_BITS) begin
            nb = s.nl[bitpos-FRAC_BITS];
        end
        rs = {s.r, nb};
        if (rs >= {1'b0, s.d}) begin
            rs          = rs - {1'b0, s.d};
            o.q[bitpos] = 1'b1;
        end
        o.r = rs[63:0];
        return o;
    endfunction

    t_dstg         w_in;
    t_dstg         r_st [NSTG];
    t_dstg         n_st [NSTG];
    logic [NSTG-1:0] r_v;
    logic [NSTG-1:0] w_rdy;

    // Seed the remainder with the upper numerator bits
    always_comb begin
        w_in.d    = i_den;
        w_in.r    = i_num >> DIVN;
        w_in.q    = '0;
        w_in.nl   = i_num[DIVN-1:0];
        w_in.side = i_side;
    end

    generate
        for (genvar k = 0; k < NSTG; k++) begin : g_stg
            // Stage advances when empty or when downstream takes its item
            if (k == NSTG - 1) begin : g_last
                assign w_rdy[k] = !r_v[k] || i_ready;
            end else begin : g_mid
                assign w_rdy[k] = !r_v[k] || w_rdy[k+1];
            end

            if (k == 0) begin : g_first
                assign n_st[k] = div_step(w_in, T_W - 1 - k);
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (w_rdy[k]) begin
                        r_v[k] <= i_valid;
                    end
                end
            end else begin : g_next
                assign n_st[k] = div_step(r_st[k-1], T_W - 1 - k);
                always_ff @(posedge i_clk) begin
                    if (!i_rst_n) begin
                        r_v[k] <= 1'b0;
                    end else if (w_rdy[k]) begin
                        r_v[k] <= r_v[k-1];
                    end
                end
            end

            // Payload: no reset
            always_ff @(posedge i_clk) begin
                if (w_rdy[k]) begin
                    r_st[k] <= n_st[k];
                end
            end
        end
    endgenerate

    assign o_ready = w_rdy[0];
    assign o_valid = r_v[NSTG-1];
    assign o_quot  = r_st[NSTG-1].q;
    assign o_side  = r_st[NSTG-1].side;

endmodule

// File: hw/rtl/ray_segment_intersect_unit.sv
// ============================================================================
// ray_segment_intersect_unit
// Tests a stream of 2D rays against one configured segment and reports the hit
// point in signed fixed point and the ray distance in unsigned fixed point.
// ============================================================================
// One ray enters per clock and one result leaves per clock when the output
// side keeps up. A ray passes four front stages (difference, products,
// cross terms, checks), a 31-stage divider that resolves one bit of t per
// stage, and three back stages (threshold, t*dir product, hit point). The
// output register holds a result while the pipeline keeps accepting rays
// into its empty stages. Write configuration only while no ray is in flight.
module ray_segment_intersect_unit (
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input rays
    input  logic          i_s_axis_tvalid,
    output logic          o_s_axis_tready,
    input  logic [127:0]  i_s_axis_tdata,   // origin_x, origin_y, dir_x, dir_y
    // Results
    output logic          o_m_axis_tvalid,
    input  logic          i_m_axis_tready,
    output logic [95:0]   o_m_axis_tdata,   // hit_x, hit_y, distance, pad
    output logic [0:0]    o_m_axis_tuser,   // hit
    // Configuration writes
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [2:0]    i_cfg_index,
    input  logic [31:0]   i_cfg_data
);
    import rsi_pkg::*;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic signed [31:0] r_start_x, r_start_y, r_span_x, r_span_y;
    logic [31:0]        r_par_thr;
    logic [T_W-1:0]     r_min_dist;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_x  <= '0;
            r_start_y  <= '0;
            r_span_x   <= 32'sd65536;
            r_span_y   <= '0;
            r_par_thr  <= 32'd1;
            r_min_dist <= T_W'(1);
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_START_X:  r_start_x  <= i_cfg_data;
                CFG_START_Y:  r_start_y  <= i_cfg_data;
                CFG_SPAN_X:   r_span_x   <= i_cfg_data;
                CFG_SPAN_Y:   r_span_y   <= i_cfg_data;
                CFG_PAR_THR:  r_par_thr  <= i_cfg_data;
                CFG_MIN_DIST: r_min_dist <= i_cfg_data[T_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Ready chain
    // ------------------------------------------------------------------
    logic r_a_valid, r_b_valid, r_c_valid, r_d_valid;
    logic r_e_valid, r_f_valid, r_g_valid;
    logic w_a_rdy, w_b_rdy, w_c_rdy, w_d_rdy, w_e_rdy, w_f_rdy, w_g_rdy;
    logic w_div_in_rdy, w_div_valid;
    logic [T_W-1:0] w_div_quot;
    t_side          w_div_side;

    assign w_g_rdy = !r_g_valid || i_m_axis_tready;
    assign w_f_rdy = !r_f_valid || w_g_rdy;
    assign w_e_rdy = !r_e_valid || w_f_rdy;
    assign w_d_rdy = !r_d_valid || w_div_in_rdy;
    assign w_c_rdy = !r_c_valid || w_d_rdy;
    assign w_b_rdy = !r_b_valid || w_c_rdy;
    assign w_a_rdy = !r_a_valid || w_b_rdy;

    assign o_s_axis_tready = w_a_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_e_valid <= 1'b0;
            r_f_valid <= 1'b0;
            r_g_valid <= 1'b0;
        end else begin
            if (w_a_rdy) r_a_valid <= i_s_axis_tvalid;
            if (w_b_rdy) r_b_valid <= r_a_valid;
            if (w_c_rdy) r_c_valid <= r_b_valid;
            if (w_d_rdy) r_d_valid <= r_c_valid;
            if (w_e_rdy) r_e_valid <= w_div_valid;
            if (w_f_rdy) r_f_valid <= r_e_valid;
            if (w_g_rdy) r_g_valid <= r_f_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage A: capture ray, form W = S - O (saturated)
    // ------------------------------------------------------------------
    logic signed [31:0] w_in_ox, w_in_oy, w_in_dx, w_in_dy;
    logic signed [31:0] r_a_ox, r_a_oy, r_a_dx, r_a_dy, r_a_wx, r_a_wy;

    assign w_in_ox = i_s_axis_tdata[31:0];
    assign w_in_oy = i_s_axis_tdata[63:32];
    assign w_in_dx = i_s_axis_tdata[95:64];
    assign w_in_dy = i_s_axis_tdata[127:96];

    always_ff @(posedge i_clk) begin
        if (w_a_rdy) begin
            r_a_ox <= w_in_ox;
            r_a_oy <= w_in_oy;
            r_a_dx <= w_in_dx;
            r_a_dy <= w_in_dy;
            r_a_wx <= sat_s32(65'(r_start_x) - 65'(w_in_ox));
            r_a_wy <= sat_s32(65'(r_start_y) - 65'(w_in_oy));
        end
    end

    // ------------------------------------------------------------------
    // Stage B: six exact 32x32 products
    // ------------------------------------------------------------------
    logic signed [31:0] r_b_ox, r_b_oy, r_b_dx, r_b_dy;
    logic signed [63:0] r_b_dvy, r_b_dyvx, r_b_wvy, r_b_wyvx, r_b_wdy, r_b_wydx;

    always_ff @(posedge i_clk) begin
        if (w_b_rdy) begin
            r_b_ox   <= r_a_ox;
            r_b_oy   <= r_a_oy;
            r_b_dx   <= r_a_dx;
            r_b_dy   <= r_a_dy;
            r_b_dvy  <= r_a_dx * r_span_y;
            r_b_dyvx <= r_a_dy * r_span_x;
            r_b_wvy  <= r_a_wx * r_span_y;
            r_b_wyvx <= r_a_wy * r_span_x;
            r_b_wdy  <= r_a_wx * r_a_dy;
            r_b_wydx <= r_a_wy * r_a_dx;
        end
    end

    // ------------------------------------------------------------------
    // Stage C: denominator and both numerators
    // ------------------------------------------------------------------
    logic signed [31:0] r_c_ox, r_c_oy, r_c_dx, r_c_dy;
    logic signed [63:0] r_c_den, r_c_nt, r_c_ns;

    always_ff @(posedge i_clk) begin
        if (w_c_rdy) begin
            r_c_ox  <= r_b_ox;
            r_c_oy  <= r_b_oy;
            r_c_dx  <= r_b_dx;
            r_c_dy  <= r_b_dy;
            r_c_den <= r_b_dvy - r_b_dyvx;
            r_c_nt  <= r_b_wvy - r_b_wyvx;
            r_c_ns  <= r_b_wdy - r_b_wydx;
        end
    end

    // ------------------------------------------------------------------
    // Stage D: parallel, segment-range and sign checks; saturation flag
    // ------------------------------------------------------------------
    logic [63:0] w_c_aden, w_c_ant, w_c_ans;
    logic        w_c_neg, w_c_pass, w_c_sat;
    logic [63:0] r_d_aden, r_d_ant;
    t_side       r_d_side;

    always_comb begin
        w_c_neg  = r_c_den[63];
        w_c_aden = w_c_neg ? 64'(-r_c_den) : 64'(r_c_den);
        w_c_ant  = r_c_nt[63] ? 64'(-r_c_nt) : 64'(r_c_nt);
        w_c_ans  = r_c_ns[63] ? 64'(-r_c_ns) : 64'(r_c_ns);
        w_c_pass = 1'b1;
        // Reject near-parallel rays
        if (!(128'(w_c_aden) > (128'(r_par_thr) << (2 * FRAC_BITS)))) begin
            w_c_pass = 1'b0;
        end
        // Reject s < 0
        if ((r_c_ns != 64'sd0) && (r_c_ns[63] != w_c_neg)) begin
            w_c_pass = 1'b0;
        end
        // Reject s > 1
        if (w_c_ans > w_c_aden) begin
            w_c_pass = 1'b0;
        end
        // Reject t <= 0
        if ((r_c_nt == 64'sd0) || (r_c_nt[63] != w_c_neg)) begin
            w_c_pass = 1'b0;
        end
        // Quotient at or above 2^(T_W-FRAC_BITS) saturates
        w_c_sat = ({{DIVN{1'b0}}, w_c_ant} >= {w_c_aden, {DIVN{1'b0}}});
    end

    always_ff @(posedge i_clk) begin
        if (w_d_rdy) begin
            r_d_aden      <= w_c_aden;
            r_d_ant       <= w_c_ant;
            r_d_side.ox   <= r_c_ox;
            r_d_side.oy   <= r_c_oy;
            r_d_side.dx   <= r_c_dx;
            r_d_side.dy   <= r_c_dy;
            r_d_side.pass <= w_c_pass;
            r_d_side.sat  <= w_c_sat;
        end
    end

    // ------------------------------------------------------------------
    // Divider: t = |nt| / |den| with FRAC_BITS fraction bits
    // ------------------------------------------------------------------
    rsi_divider u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_d_valid),
        .o_ready (w_div_in_rdy),
        .i_num   (r_d_ant),
        .i_den   (r_d_aden),
        .i_side  (r_d_side),
        .o_valid (w_div_valid),
        .i_ready (w_e_rdy),
        .o_quot  (w_div_quot),
        .o_side  (w_div_side)
    );

    // ------------------------------------------------------------------
    // Stage E: saturate t, compare against minimum distance
    // ------------------------------------------------------------------
    logic [T_W-1:0]     w_div_t;
    logic [T_W-1:0]     r_e_t;
    logic               r_e_pass;
    logic signed [31:0] r_e_ox, r_e_oy, r_e_dx, r_e_dy;

    assign w_div_t = w_div_side.sat ? MAX_T : w_div_quot;

    always_ff @(posedge i_clk) begin
        if (w_e_rdy) begin
            r_e_t    <= w_div_t;
            r_e_pass <= w_div_side.pass && (w_div_t > r_min_dist);
            r_e_ox   <= w_div_side.ox;
            r_e_oy   <= w_div_side.oy;
            r_e_dx   <= w_div_side.dx;
            r_e_dy   <= w_div_side.dy;
        end
    end

    // ------------------------------------------------------------------
    // Stage F: t * dir
    // ------------------------------------------------------------------
    logic signed [63:0] r_f_px, r_f_py;
    logic signed [31:0] r_f_ox, r_f_oy;
    logic [T_W-1:0]     r_f_t;
    logic               r_f_pass;

    always_ff @(posedge i_clk) begin
        if (w_f_rdy) begin
            r_f_px   <= $signed({1'b0, r_e_t}) * r_e_dx;
            r_f_py   <= $signed({1'b0, r_e_t}) * r_e_dy;
            r_f_ox   <= r_e_ox;
            r_f_oy   <= r_e_oy;
            r_f_t    <= r_e_t;
            r_f_pass <= r_e_pass;
        end
    end

    // ------------------------------------------------------------------
    // Stage G: floor to FRAC_BITS, add origin, saturate; zero on miss
    // ------------------------------------------------------------------
    logic signed [63:0] w_f_stepx, w_f_stepy;
    logic signed [31:0] r_g_x, r_g_y;
    logic [T_W-1:0]     r_g_dist;
    logic               r_g_hit;

    assign w_f_stepx = r_f_px >>> FRAC_BITS;
    assign w_f_stepy = r_f_py >>> FRAC_BITS;

    always_ff @(posedge i_clk) begin
        if (w_g_rdy) begin
            r_g_hit  <= r_f_pass;
            r_g_x    <= r_f_pass ? sat_s32(65'(r_f_ox) + 65'(w_f_stepx)) : 32'sd0;
            r_g_y    <= r_f_pass ? sat_s32(65'(r_f_oy) + 65'(w_f_stepy)) : 32'sd0;
            r_g_dist <= r_f_pass ? r_f_t : '0;
        end
    end

    assign o_m_axis_tvalid = r_g_valid;
    assign o_m_axis_tdata  = {1'b0, r_g_dist, r_g_y, r_g_x};
    assign o_m_axis_tuser  = r_g_hit;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_valid && !r_g_hit) |-> (r_g_x == 32'sd0 && r_g_y == 32'sd0 && r_g_dist == '0))
        else $error("miss result carries nonzero fields");

    a_hit_dist: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_g_valid && r_g_hit) |-> (r_g_dist > r_min_dist))
        else $error("hit distance not above minimum");

    a_empty_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_g_valid |-> o_s_axis_tready)
        else $error("input stalled while output stage empty");

    a_pass_nonzero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_d_valid && r_d_side.pass) |-> (r_d_aden != 64'd0))
        else $error("passing ray with zero denominator");

endmodule
